>>> hdl/kers_pkg.sv
// types, constants and codes shared by the key event repeat scheduler
package kers_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned HELD_DEPTH_DEF  = 8;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned GAP_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [GAP_W-1:0] QUEUE_GAP_RST  = 8'd10;
  localparam logic [GAP_W-1:0] REPEAT_GAP_RST = 8'd18;
  localparam logic [KEY_W-1:0] SHIFT_KEY_RST  = 8'd1;
  localparam logic [KEY_W-1:0] CTRL_KEY_RST   = 8'd2;
  localparam logic [KEY_W-1:0] GRAPH_KEY_RST  = 8'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_STROKE  = 3'd1,
    CMD_PRESS   = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_RAW     = 3'd5
  } kers_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUEUE_GAP  = 3'd0,
    CFG_REPEAT_GAP = 3'd1,
    CFG_SHIFT_KEY  = 3'd2,
    CFG_CTRL_KEY   = 3'd3,
    CFG_GRAPH_KEY  = 3'd4
  } kers_cfg_idx_e;

  // one key operation per step: presses first, then releases
  typedef enum logic [2:0] {
    STP_SHIFT_DN = 3'd0,
    STP_CTRL_DN  = 3'd1,
    STP_GRAPH_DN = 3'd2,
    STP_KEY_DN   = 3'd3,
    STP_KEY_UP   = 3'd4,
    STP_SHIFT_UP = 3'd5,
    STP_CTRL_UP  = 3'd6,
    STP_GRAPH_UP = 3'd7
  } kers_step_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_HRD,
    ST_HCMP,
    ST_MRD,
    ST_MWR,
    ST_TPOP,
    ST_TREP
  } kers_state_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_code;
    logic             with_shift;
    logic             with_ctrl;
    logic             with_graph;
    logic             raw_press;
  } kers_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] sent_key;
    logic             sent_press;
    logic             overflow;
  } kers_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [GAP_W-1:0]     wdata;
  } kers_cfg_t;

  typedef struct packed {
    logic             press;
    logic [KEY_W-1:0] key;
  } kers_evt_t;

endpackage

>>> hdl/kers_chan_if.sv
// valid/ready channel carrying one payload item
interface kers_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/key_event_repeat_scheduler_top.sv
// key event repeat scheduler: command sequencer over event fifo and held-key memories
//
//   channel | dir | payload     | accepted when
//   in_i    | in  | kers_in_t   | in_i.valid && in_i.ready
//   res_o   | out | kers_out_t  | res_o.valid && res_o.ready
//   cfg_i   | in  | kers_cfg_t  | cfg_i.valid && cfg_i.ready (always ready)
//
// tick: taken in idle; it goes on to pop or repeat when due, and waits while the result slot is full
// raw event and clear all: done as the item is taken; unused codes are ignored
// press/release: the item is taken, then each key step probes the held entries in turn;
//   a release that removes an entry then moves each later entry up in the held-key
//   memory
// reset clears state, counters, pointers, flags and configuration; both memories start undefined
// a result waits in the output register while the next item is taken
module key_event_repeat_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = kers_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HELD_DEPTH  = kers_pkg::HELD_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kers_chan_if.sink   in_i,
  kers_chan_if.source res_o,
  kers_chan_if.sink   cfg_i
);
  import kers_pkg::*;

  localparam int unsigned QPW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HIW = $clog2(HELD_DEPTH);
  localparam int unsigned HCW = $clog2(HELD_DEPTH + 1);

  kers_state_e      state_q, state_d;
  kers_step_e       step_q, step_d, step_end_q, step_end_d, step_next;
  logic [2:0]       mods_q, mods_d;
  logic [KEY_W-1:0] key_q, key_d, op_key_q, op_key_d;
  logic [HCW-1:0]   idx_q, idx_d, idx_p1;
  logic [QPW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [QCW-1:0]   fcount_q, fcount_d;
  logic [HCW-1:0]   hcount_q, hcount_d;
  logic [GAP_W-1:0] elapsed_q, elapsed_d, elap_inc;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  kers_out_t        out_q, out_d;

  logic [GAP_W-1:0] qgap_q, rgap_q;
  logic [KEY_W-1:0] shift_q, ctrl_q, graph_q;

  kers_evt_t        fifo_mem [QUEUE_DEPTH];
  kers_evt_t        f_rdata_q;
  kers_evt_t        push_evt;
  logic             push_req;

  logic [KEY_W-1:0] held_mem [HELD_DEPTH];
  logic [KEY_W-1:0] h_rdata_q, h_wdata;
  logic [HIW-1:0]   h_raddr, h_waddr;
  logic             h_we, f_we;

  logic             in_acc, out_free, op_done;
  logic             step_en, step_dn, step_last;
  logic [KEY_W-1:0] step_code;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || res_o.ready;
  assign elap_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + GAP_W'(1);
  assign idx_p1    = idx_q + HCW'(1);
  assign step_last = (step_q == step_end_q);
  assign step_next = kers_step_e'(3'(step_q + 3'd1));

  always_comb begin
    step_en   = 1'b1;
    step_dn   = 1'b0;
    step_code = key_q;
    case (step_q)
      STP_SHIFT_DN: begin step_en = mods_q[2]; step_dn = 1'b1; step_code = shift_q; end
      STP_CTRL_DN:  begin step_en = mods_q[1]; step_dn = 1'b1; step_code = ctrl_q;  end
      STP_GRAPH_DN: begin step_en = mods_q[0]; step_dn = 1'b1; step_code = graph_q; end
      STP_KEY_DN:   begin step_dn = 1'b1; end
      STP_KEY_UP:   begin end
      STP_SHIFT_UP: begin step_en = mods_q[2]; step_code = shift_q; end
      STP_CTRL_UP:  begin step_en = mods_q[1]; step_code = ctrl_q;  end
      STP_GRAPH_UP: begin step_en = mods_q[0]; step_code = graph_q; end
      default:      begin step_en = 1'b0; end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    step_end_d  = step_end_q;
    mods_d      = mods_q;
    key_d       = key_q;
    op_key_d    = op_key_q;
    idx_d       = idx_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fcount_d    = fcount_q;
    hcount_d    = hcount_q;
    elapsed_d   = elapsed_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    push_req    = 1'b0;
    push_evt    = '{press: 1'b0, key: op_key_q};
    f_we        = 1'b0;
    h_we        = 1'b0;
    h_waddr     = hcount_q[HIW-1:0];
    h_wdata     = op_key_q;
    h_raddr     = idx_q[HIW-1:0];
    op_done     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        h_raddr = HIW'(hcount_q - HCW'(1));
        if (in_acc) begin
          key_d  = in_i.data.key_code;
          mods_d = {in_i.data.with_shift, in_i.data.with_ctrl, in_i.data.with_graph};
          case (kers_cmd_e'(in_i.data.cmd))
            CMD_TICK: begin
              elapsed_d = elap_inc;
              if (fcount_q != '0) begin
                if (elap_inc >= qgap_q) begin
                  state_d = ST_TPOP;
                end
              end else if (hcount_q != '0 && elap_inc >= rgap_q) begin
                state_d = ST_TREP;
              end
            end
            CMD_STROKE: begin
              step_d     = STP_SHIFT_DN;
              step_end_d = STP_GRAPH_UP;
              state_d    = ST_STEP;
            end
            CMD_PRESS: begin
              step_d     = STP_SHIFT_DN;
              step_end_d = STP_KEY_DN;
              state_d    = ST_STEP;
            end
            CMD_RELEASE: begin
              step_d     = STP_KEY_UP;
              step_end_d = STP_GRAPH_UP;
              state_d    = ST_STEP;
            end
            CMD_CLEAR: begin
              head_d    = '0;
              tail_d    = '0;
              fcount_d  = '0;
              hcount_d  = '0;
              elapsed_d = '0;
            end
            CMD_RAW: begin
              push_req = 1'b1;
              push_evt = '{press: in_i.data.raw_press, key: in_i.data.key_code};
            end
            default: begin end
          endcase
        end
      end

      ST_STEP: begin
        op_key_d = step_code;
        idx_d    = '0;
        if (!step_en) begin
          op_done = 1'b1;
        end else begin
          if (!step_dn) begin
            push_req = 1'b1;
            push_evt = '{press: 1'b0, key: step_code};
          end
          state_d = ST_HRD;
        end
      end

      // probe held entry idx, or act on a miss
      ST_HRD: begin
        if (idx_q == hcount_q) begin
          if (step_dn) begin
            push_req = 1'b1;
            push_evt = '{press: 1'b1, key: op_key_q};
            if (hcount_q == HCW'(HELD_DEPTH)) begin
              ovf_d = 1'b1;
            end else begin
              h_we     = 1'b1;
              hcount_d = hcount_q + HCW'(1);
            end
          end
          op_done = 1'b1;
        end else begin
          state_d = ST_HCMP;
        end
      end

      ST_HCMP: begin
        if (h_rdata_q == op_key_q) begin
          if (step_dn) begin
            op_done = 1'b1;
          end else begin
            state_d = ST_MRD;
          end
        end else begin
          idx_d   = idx_p1;
          state_d = ST_HRD;
        end
      end

      // move the tail of the held list up by one entry
      ST_MRD: begin
        h_raddr = idx_p1[HIW-1:0];
        if (idx_p1 < hcount_q) begin
          state_d = ST_MWR;
        end else begin
          hcount_d = hcount_q - HCW'(1);
          op_done  = 1'b1;
        end
      end

      ST_MWR: begin
        h_we    = 1'b1;
        h_waddr = idx_q[HIW-1:0];
        h_wdata = h_rdata_q;
        idx_d   = idx_p1;
        state_d = ST_MRD;
      end

      ST_TPOP: begin
        if (out_free) begin
          head_d   = (head_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPW'(1);
          fcount_d = fcount_q - QCW'(1);
          if (f_rdata_q.key != '0) begin
            out_d       = '{sent_key: f_rdata_q.key, sent_press: f_rdata_q.press,
                            overflow: ovf_q};
            out_valid_d = 1'b1;
            elapsed_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end

      ST_TREP: begin
        h_raddr = HIW'(hcount_q - HCW'(1));
        if (out_free) begin
          if (h_rdata_q != '0) begin
            out_d       = '{sent_key: h_rdata_q, sent_press: 1'b1, overflow: ovf_q};
            out_valid_d = 1'b1;
            elapsed_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (push_req) begin
      if (fcount_q == QCW'(QUEUE_DEPTH)) begin
        ovf_d = 1'b1;
      end else begin
        f_we     = 1'b1;
        tail_d   = (tail_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QPW'(1);
        fcount_d = fcount_q + QCW'(1);
      end
    end

    if (op_done) begin
      if (step_last) begin
        state_d = ST_IDLE;
      end else begin
        step_d  = step_next;
        state_d = ST_STEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STP_SHIFT_DN;
      step_end_q  <= STP_SHIFT_DN;
      idx_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fcount_q    <= '0;
      hcount_q    <= '0;
      elapsed_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      step_end_q  <= step_end_d;
      idx_q       <= idx_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fcount_q    <= fcount_d;
      hcount_q    <= hcount_d;
      elapsed_q   <= elapsed_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mods_q   <= mods_d;
    key_q    <= key_d;
    op_key_q <= op_key_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qgap_q  <= QUEUE_GAP_RST;
      rgap_q  <= REPEAT_GAP_RST;
      shift_q <= SHIFT_KEY_RST;
      ctrl_q  <= CTRL_KEY_RST;
      graph_q <= GRAPH_KEY_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (kers_cfg_idx_e'(cfg_i.data.index))
        CFG_QUEUE_GAP:  qgap_q  <= cfg_i.data.wdata;
        CFG_REPEAT_GAP: rgap_q  <= cfg_i.data.wdata;
        CFG_SHIFT_KEY:  shift_q <= cfg_i.data.wdata;
        CFG_CTRL_KEY:   ctrl_q  <= cfg_i.data.wdata;
        CFG_GRAPH_KEY:  graph_q <= cfg_i.data.wdata;
        default: begin end
      endcase
    end
  end

  // event fifo memory, read port follows the head
  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fifo_mem[tail_q] <= push_evt;
    end
    f_rdata_q <= fifo_mem[head_q];
  end

  // held-key memory
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      held_mem[h_waddr] <= h_wdata;
    end
    h_rdata_q <= held_mem[h_raddr];
  end

endmodule

>>> hdl/kers_checker.sv
// port-level checks for the key event repeat scheduler, bound to the top level
module kers_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [kers_pkg::CMD_W-1:0]  in_cmd_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input kers_pkg::kers_out_t         res_data_i
);
  import kers_pkg::*;

  logic vld_prev_q, hs_prev_q, ovf_seen_q, tick_seen_q, tick_seen_d;
  logic new_res, tick_acc;

  assign new_res  = res_valid_i && (!vld_prev_q || hs_prev_q);
  assign tick_acc = in_valid_i && in_ready_i && (in_cmd_i == CMD_TICK);

  always_comb begin
    tick_seen_d = tick_seen_q;
    if (new_res) begin
      tick_seen_d = 1'b0;
    end
    if (tick_acc) begin
      tick_seen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_prev_q  <= 1'b0;
      hs_prev_q   <= 1'b0;
      ovf_seen_q  <= 1'b0;
      tick_seen_q <= 1'b0;
    end else begin
      vld_prev_q  <= res_valid_i;
      hs_prev_q   <= res_valid_i && res_ready_i;
      ovf_seen_q  <= ovf_seen_q || (res_valid_i && res_data_i.overflow);
      tick_seen_q <= tick_seen_d;
    end
  end

  a_idle_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  a_no_null_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_data_i.sent_key != '0))
    else $error("null key sent");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_data_i)))
    else $error("stalled result changed");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && ovf_seen_q) |-> res_data_i.overflow)
    else $error("overflow flag dropped");

  a_result_needs_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_res |-> tick_seen_q)
    else $error("result without a tick");

endmodule

bind key_event_repeat_scheduler_top kers_checker u_kers_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_cmd_i   (in_i.data.cmd),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_data_i (res_o.data)
);
